/* design/ps2kr_pkg.sv */
// Package for the PS/2 scan-code receiver: payload structs, command codes,
// buffer sizing and configuration register indexes. No dependencies.
package ps2kr_pkg;

  // Event buffer sizing
  localparam int MAX_EVENT_BYTES = 4;
  localparam int LEN_W           = $clog2(MAX_EVENT_BYTES + 1);
  localparam int IDX_W           = $clog2(MAX_EVENT_BYTES);

  // Word framing positions
  localparam logic [3:0] POS_START  = 4'd0;
  localparam logic [3:0] POS_DATA_L = 4'd8;
  localparam logic [3:0] POS_PARITY = 4'd9;

  localparam logic [15:0] IDLE_MAX = 16'hFFFF;

  // Input operation codes
  localparam logic OP_EDGE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Command kinds between front and back
  localparam logic CMD_ABORT = 1'b0;
  localparam logic CMD_BYTE  = 1'b1;

  // Command queue depth
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Configuration register indexes
  localparam logic [2:0] REG_PARITY_EN   = 3'd0;
  localparam logic [2:0] REG_TIMEOUT_EN  = 3'd1;
  localparam logic [2:0] REG_TIMEOUT_TCK = 3'd2;
  localparam logic [2:0] REG_RELEASE     = 3'd3;
  localparam logic [2:0] REG_EXTENDED    = 3'd4;

  typedef struct packed {
    logic operation;
    logic data_bit;
  } in_t;

  typedef struct packed {
    logic [7:0] byte_first;
    logic [7:0] byte_second;
    logic [7:0] byte_third;
    logic [7:0] byte_fourth;
    logic [2:0] byte_count;
    logic       overflowed;
  } res_t;

  typedef struct packed {
    logic        parity_check_enable;
    logic        timeout_enable;
    logic [15:0] timeout_ticks;
    logic [7:0]  release_prefix;
    logic [7:0]  extended_prefix;
  } cfg_t;

  typedef struct packed {
    logic       kind;
    logic       last;
    logic [7:0] data;
  } cmd_t;

endpackage

/* design/ps2kr_front.sv */
// Front end: frames PS/2 words, tracks idle time and pending events, and
// issues byte and abort commands. Depends on ps2kr_pkg.
module ps2kr_front import ps2kr_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  input  logic accept,
  input  in_t  item,
  output logic cmd_push,
  output cmd_t cmd
);

  logic [3:0]  bit_position, bit_position_next;
  logic [7:0]  shift_value, shift_value_next;
  logic        parity_acc, parity_acc_next;
  logic        pending, pending_next;
  logic [15:0] idle_ticks, idle_ticks_next;

  logic       timeout_hit;
  logic [3:0] pos_eff;
  logic [7:0] byte_done;
  logic       is_prefix;

  // Classify the request and compute the next framing state
  always_comb begin
    bit_position_next = bit_position;
    shift_value_next  = shift_value;
    parity_acc_next   = parity_acc;
    pending_next      = pending;
    idle_ticks_next   = idle_ticks;
    cmd_push          = 1'b0;
    cmd.kind          = CMD_BYTE;
    cmd.last          = 1'b0;
    cmd.data          = shift_value;
    byte_done         = shift_value;
    is_prefix         = (byte_done == cfg.release_prefix) ||
                        (byte_done == cfg.extended_prefix);
    timeout_hit       = cfg.timeout_enable && pending && (idle_ticks > cfg.timeout_ticks);
    pos_eff           = timeout_hit ? POS_START : bit_position;

    if (accept) begin
      if (item.operation == OP_TICK) begin
        if (idle_ticks < IDLE_MAX) begin
          idle_ticks_next = idle_ticks + 16'd1;
        end
      end else begin
        // Drop the pending event on timeout
        if (timeout_hit) begin
          pending_next    = 1'b0;
          idle_ticks_next = '0;
          cmd_push        = 1'b1;
          cmd.kind        = CMD_ABORT;
        end
        if (pos_eff == POS_START) begin
          shift_value_next  = '0;
          parity_acc_next   = 1'b0;
          bit_position_next = 4'd1;
        end else if (pos_eff <= POS_DATA_L) begin
          shift_value_next[pos_eff[2:0] - 3'd1] = item.data_bit;
          parity_acc_next   = parity_acc ^ item.data_bit;
          bit_position_next = pos_eff + 4'd1;
        end else if (pos_eff == POS_PARITY) begin
          parity_acc_next   = parity_acc ^ item.data_bit;
          bit_position_next = pos_eff + 4'd1;
        end else begin
          // Stop bit: close the word
          bit_position_next = POS_START;
          shift_value_next  = '0;
          parity_acc_next   = 1'b0;
          idle_ticks_next   = '0;
          cmd_push          = 1'b1;
          if (cfg.parity_check_enable && !parity_acc) begin
            pending_next = 1'b0;
            cmd.kind     = CMD_ABORT;
          end else begin
            cmd.kind     = CMD_BYTE;
            cmd.last     = !is_prefix;
            pending_next = is_prefix;
          end
        end
      end
    end
  end

  // Hold framing state
  always_ff @(posedge clk) begin
    if (rst) begin
      bit_position <= POS_START;
      shift_value  <= '0;
      parity_acc   <= 1'b0;
      pending      <= 1'b0;
      idle_ticks   <= '0;
    end else begin
      bit_position <= bit_position_next;
      shift_value  <= shift_value_next;
      parity_acc   <= parity_acc_next;
      pending      <= pending_next;
      idle_ticks   <= idle_ticks_next;
    end
  end

  // Framing position stays within the word
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    bit_position <= 4'd10) else $error("bit position out of word");

  // A stop bit always returns framing to the start position
  a_stop_closes: assert property (@(posedge clk) disable iff (rst)
    (accept && item.operation == OP_EDGE && bit_position == 4'd10 && !timeout_hit)
      |=> bit_position == POS_START) else $error("stop bit did not close word");

  // A timeout abort clears the pending mark
  a_timeout_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && item.operation == OP_EDGE && timeout_hit) |=> !pending)
    else $error("pending survived timeout");

endmodule

/* design/ps2kr_cmd_queue.sv */
// Short command queue between front and back ends, held in flip-flops.
// Depends on ps2kr_pkg.
module ps2kr_cmd_queue import ps2kr_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  output logic valid,
  output cmd_t head,
  input  logic pop
);

  cmd_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push, do_pop;

  assign full    = (count == QCNT_W'(QUEUE_DEPTH));
  assign valid   = (count != '0);
  assign head    = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  // Write the tail slot
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  // Occupancy never exceeds depth
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QUEUE_DEPTH)) else $error("queue overfilled");

  // Pointers stay consistent with occupancy
  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (wr_ptr - rd_ptr) == count[QPTR_W-1:0]) else $error("queue pointers out of step");

  // A push without pop grows the queue by one
  a_grow: assert property (@(posedge clk) disable iff (rst)
    (do_push && !do_pop) |=> count == $past(count) + QCNT_W'(1))
    else $error("queue did not grow");

endmodule

/* design/ps2kr_back.sv */
// Back end: assembles event bytes from commands and holds the finished
// event in an output register. Depends on ps2kr_pkg.
module ps2kr_back import ps2kr_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  input  cmd_t cmd,
  output logic cmd_pop,
  output logic res_valid,
  output res_t res,
  input  logic res_pop
);

  logic [7:0]       event_store [MAX_EVENT_BYTES];
  logic [7:0]       store_next  [MAX_EVENT_BYTES];
  logic [LEN_W-1:0] event_len, event_len_next;
  logic             ovf, ovf_next;
  logic             completes, out_free, take;
  logic [7:0]       view [4];
  res_t             res_next;

  assign completes = (cmd.kind == CMD_BYTE) && cmd.last;
  assign out_free  = !res_valid || res_pop;
  assign cmd_pop   = cmd_valid && (!completes || out_free);
  assign take      = cmd_pop;

  // Merge the incoming byte into the buffer
  always_comb begin
    for (int k = 0; k < MAX_EVENT_BYTES; k++) begin
      store_next[k] = event_store[k];
    end
    event_len_next = event_len;
    ovf_next       = ovf;
    if (cmd.kind == CMD_BYTE) begin
      if (event_len < LEN_W'(MAX_EVENT_BYTES)) begin
        store_next[event_len[IDX_W-1:0]] = cmd.data;
        event_len_next = event_len + LEN_W'(1);
      end else begin
        ovf_next = 1'b1;
      end
    end
  end

  // Build the result from the merged buffer
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      view[k] = '0;
      if (k < MAX_EVENT_BYTES && LEN_W'(k) < event_len_next) begin
        view[k] = store_next[k % MAX_EVENT_BYTES];
      end
    end
    res_next.byte_first  = view[0];
    res_next.byte_second = view[1];
    res_next.byte_third  = view[2];
    res_next.byte_fourth = view[3];
    res_next.byte_count  = (event_len_next > LEN_W'(7)) ? 3'd7 : 3'(event_len_next);
    res_next.overflowed  = ovf_next;
  end

  // Write event bytes
  always_ff @(posedge clk) begin
    if (take) begin
      for (int k = 0; k < MAX_EVENT_BYTES; k++) begin
        event_store[k] <= store_next[k];
      end
    end
  end

  // Advance event length and overflow; clear on completion or abort
  always_ff @(posedge clk) begin
    if (rst) begin
      event_len <= '0;
      ovf       <= 1'b0;
    end else if (take) begin
      if (cmd.kind == CMD_ABORT || cmd.last) begin
        event_len <= '0;
        ovf       <= 1'b0;
      end else begin
        event_len <= event_len_next;
        ovf       <= ovf_next;
      end
    end
  end

  // Hold the finished event until popped
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (take && completes) begin
      res_valid <= 1'b1;
    end else if (res_pop) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && completes) begin
      res <= res_next;
    end
  end

  // Buffer length never exceeds capacity
  a_len_max: assert property (@(posedge clk) disable iff (rst)
    event_len <= LEN_W'(MAX_EVENT_BYTES)) else $error("event length over capacity");

  // Overflow only with a full buffer
  a_ovf_full: assert property (@(posedge clk) disable iff (rst)
    ovf |-> event_len == LEN_W'(MAX_EVENT_BYTES)) else $error("overflow with room left");

  // A completing byte never overwrites an unread result
  a_no_clobber: assert property (@(posedge clk) disable iff (rst)
    (take && completes) |-> (!res_valid || res_pop)) else $error("result overwritten");

  // Completion restarts the event
  a_restart: assert property (@(posedge clk) disable iff (rst)
    (take && completes) |=> (event_len == '0 && !ovf)) else $error("event not cleared");

endmodule

/* design/ps2_keyboard_scan_code_receiver_top.sv */
// Top level of the PS/2 scan-code receiver: configuration registers, front end,
// command queue and back end. Depends on ps2kr_pkg, ps2kr_front,
// ps2kr_cmd_queue and ps2kr_back.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------------
//  input    | push / full          | item  (operation, data_bit)
//  result   | empty / pop          | result (four bytes, count, overflow)
//  config   | cfg_valid / cfg_ready| cfg_index (3b), cfg_data (16b)
//
// One request is taken per cycle whenever full is low; full rises only when
// the four-entry command queue between front and back is full.
// A completed event passes through the command queue and then the output
// register before it shows on result, and waits there until popped; the back
// end stalls on the next completing byte while that result is unread.
// Synchronous reset restores register defaults and empties every stage.
module ps2_keyboard_scan_code_receiver_top import ps2kr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  in_t         item,
  output logic        empty,
  input  logic        pop,
  output res_t        result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t cfg;
  logic accept;
  logic cmd_push, q_valid, q_pop, res_valid;
  cmd_t cmd_in, q_head;

  assign cfg_ready = 1'b1;
  assign accept    = push && !full;
  assign empty     = !res_valid;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.parity_check_enable <= 1'b1;
      cfg.timeout_enable      <= 1'b1;
      cfg.timeout_ticks       <= 16'd2;
      cfg.release_prefix      <= 8'hF0;
      cfg.extended_prefix     <= 8'hE0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PARITY_EN:   cfg.parity_check_enable <= cfg_data[0];
        REG_TIMEOUT_EN:  cfg.timeout_enable      <= cfg_data[0];
        REG_TIMEOUT_TCK: cfg.timeout_ticks       <= cfg_data;
        REG_RELEASE:     cfg.release_prefix      <= cfg_data[7:0];
        REG_EXTENDED:    cfg.extended_prefix     <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  ps2kr_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .accept   (accept),
    .item     (item),
    .cmd_push (cmd_push),
    .cmd      (cmd_in)
  );

  ps2kr_cmd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (cmd_push),
    .push_cmd (cmd_in),
    .full     (full),
    .valid    (q_valid),
    .head     (q_head),
    .pop      (q_pop)
  );

  ps2kr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (q_valid),
    .cmd       (q_head),
    .cmd_pop   (q_pop),
    .res_valid (res_valid),
    .res       (result),
    .res_pop   (pop)
  );

endmodule
